// ===== src/sidd_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the pipeline payload type, digit constants and the shift-add-3 step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sidd_pkg;
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W = 4 * NUM_DIGITS;
  localparam int BITS_PER_STAGE = 8;
  localparam int NUM_STAGES = 64 / BITS_PER_STAGE;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic [63:0]      bin;
    logic [BCD_W-1:0] bcd;
    logic             neg;
    logic             zero;
    logic [5:0]       pad;
  } pipe_t;

  function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return res;
  endfunction
endpackage
`default_nettype wire

// ===== src/sidd_if.sv =====
// Channel interfaces for the converter: input beats and character beats.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sidd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [5:0]  min_digits;
  modport source (output valid, value, min_digits, input ready);
  modport sink (input valid, value, min_digits, output ready);
endinterface

interface sidd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;
  modport source (output valid, char_code, is_last, input ready);
  modport sink (input valid, char_code, is_last, output ready);
endinterface
`default_nettype wire

// ===== src/sidd_dabble_stage.sv =====
// One pipeline stage of the binary to BCD conversion: eight shift-add-3 steps.
// Depends on sidd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sidd_dabble_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sidd_pkg::pipe_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sidd_pkg::pipe_t    out_data
);
  import sidd_pkg::*;

  logic  valid_r;
  pipe_t data_r;
  pipe_t data_nxt;

  assign in_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data = data_r;

  always_comb begin
    data_nxt = in_data;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      data_nxt.bcd = dabble_adjust(data_nxt.bcd);
      data_nxt.bcd = {data_nxt.bcd[BCD_W-2:0], data_nxt.bin[63]};
      data_nxt.bin = {data_nxt.bin[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// Top level of the signed 64-bit integer to decimal ASCII converter.
// Depends on sidd_pkg, sidd_if and sidd_dabble_stage.
//
// Channel  Dir  Payload
// in_ch    in   value[63:0] signed, min_digits[5:0]
// out_ch   out  char_code[7:0], is_last
//
// An input beat passes an entry register, eight conversion stages of eight
// bits each and a length stage, then the output register emits one character
// per cycle while out_ch is ready; a number of n characters, n from 1 to
// max(20, MAX_PAD_DIGITS) + 1, frees the serializer on its last character.
// Reset clears all valid bits; stalls freeze each full stage in place.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii_top #(
  parameter int MAX_PAD_DIGITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sidd_in_if.sink    in_ch,
  sidd_out_if.source out_ch
);
  import sidd_pkg::*;

  localparam logic [5:0] PAD_CAP = 6'(MAX_PAD_DIGITS);

  logic  ent_valid_r;
  pipe_t ent_r;
  logic  ent_ready;
  logic  [NUM_STAGES:0] st_valid;
  logic  [NUM_STAGES:0] st_ready;
  pipe_t st_data [NUM_STAGES+1];

  assign in_ch.ready = !ent_valid_r || ent_ready;
  assign ent_ready = st_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      ent_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      ent_r.neg  <= in_ch.value[63];
      ent_r.bin  <= in_ch.value[63] ? (64'd0 - in_ch.value) : in_ch.value;
      ent_r.bcd  <= '0;
      ent_r.zero <= (in_ch.value == 64'd0);
      ent_r.pad  <= (in_ch.min_digits > PAD_CAP) ? PAD_CAP : in_ch.min_digits;
    end
  end

  assign st_valid[0] = ent_valid_r;
  assign st_data[0] = ent_r;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    sidd_dabble_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_data   (st_data[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_data  (st_data[g+1])
    );
  end

  // Length stage.
  logic             len_valid_r;
  logic [BCD_W-1:0] len_bcd_r;
  logic             len_neg_r;
  logic [5:0]       len_nd_r;
  logic             len_ready;
  logic [5:0]       dig_len;
  logic [5:0]       nd_nxt;
  pipe_t            last_d;

  assign last_d = st_data[NUM_STAGES];
  assign st_ready[NUM_STAGES] = !len_valid_r || len_ready;

  always_comb begin
    dig_len = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (last_d.bcd[4*d +: 4] != 4'd0) begin
        dig_len = 6'(d + 1);
      end
    end
    if (last_d.zero) begin
      nd_nxt = 6'd1;
    end else if (dig_len > last_d.pad) begin
      nd_nxt = dig_len;
    end else begin
      nd_nxt = last_d.pad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_valid_r <= 1'b0;
    end else if (st_ready[NUM_STAGES]) begin
      len_valid_r <= st_valid[NUM_STAGES];
    end
    if (st_ready[NUM_STAGES] && st_valid[NUM_STAGES]) begin
      len_bcd_r <= last_d.bcd;
      len_neg_r <= last_d.neg && !last_d.zero;
      len_nd_r  <= nd_nxt;
    end
  end

  // Character serializer.
  logic             busy_r;
  logic             sign_r;
  logic [5:0]       pos_r;
  logic [BCD_W-1:0] bcd_r;
  logic [3:0]       digit;
  logic             last_char;
  logic             out_beat;

  assign last_char = !sign_r && (pos_r == 6'd0);
  assign out_beat = busy_r && out_ch.ready;
  assign len_ready = !busy_r || (out_beat && last_char);

  always_comb begin
    if (pos_r < 6'(NUM_DIGITS)) begin
      digit = bcd_r[4*pos_r[4:0] +: 4];
    end else begin
      digit = 4'd0;
    end
  end

  assign out_ch.valid = busy_r;
  assign out_ch.char_code = sign_r ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digit});
  assign out_ch.is_last = last_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      pos_r  <= '0;
    end else if (len_ready) begin
      busy_r <= len_valid_r;
      if (len_valid_r) begin
        sign_r <= len_neg_r;
        pos_r  <= len_nd_r - 6'd1;
      end
    end else if (out_beat) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        pos_r <= pos_r - 6'd1;
      end
    end
    if (len_ready && len_valid_r) begin
      bcd_r <= len_bcd_r;
    end
  end
endmodule
`default_nettype wire
